// ===== src/ffba_pkg.sv =====
// Shared constants, widths and types of the first-fit block allocator.
`default_nettype none

package ffba_pkg;

    // Default table depth and header size
    localparam int MAX_BLOCKS_DEF   = 64;
    localparam int HEADER_BYTES_DEF = 16;

    // Field widths
    localparam int OPCODE_W = 1;
    localparam int SIZE_W   = 20;
    localparam int ADDR_W   = 21;
    localparam int STATUS_W = 2;
    localparam int MIN_W    = 16;
    localparam int POOL_W   = 20;

    // Configuration channel
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_ALLOC = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL      = 2'd1;

    localparam logic [MIN_W-1:0]  MIN_ALLOC_RST = 16'd8;
    localparam logic [POOL_W-1:0] POOL_RST      = 20'd10240;

    // Opcodes
    localparam logic [OPCODE_W-1:0] OP_ALLOC = 1'b0;
    localparam logic [OPCODE_W-1:0] OP_FREE  = 1'b1;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOMEM    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd2;

    // One table entry
    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [SIZE_W-1:0] bytes;
        logic              in_use;
    } t_entry;

    // Controller to datapath
    typedef struct packed {
        logic start;      // latch request, rewind scan
        logic issue;      // read next table entry
        logic hit_wr;     // update mark of the entry under check
        logic tail;       // try to carve a new block at the bump pointer
        logic not_found;  // free found no matching block
        logic load_out;   // move result into the output register
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic more;       // entries left to read
        logic chk_vld;    // an entry is under check this cycle
        logic hit;        // entry under check matches the request
        logic is_free;    // current request is a free
    } t_dp_sts;

endpackage

`default_nettype wire

// ===== src/ffba_req_if.sv =====
// Request channel: opcode, size and address of one request beat.
`default_nettype none

interface ffba_req_if;
    logic                          valid;
    logic                          ready;
    logic [ffba_pkg::OPCODE_W-1:0] opcode;
    logic [ffba_pkg::SIZE_W-1:0]   request_bytes;
    logic [ffba_pkg::ADDR_W-1:0]   free_address;

    modport source (output valid, output opcode, output request_bytes,
                    output free_address, input ready);
    modport sink   (input valid, input opcode, input request_bytes,
                    input free_address, output ready);
endinterface

`default_nettype wire

// ===== src/ffba_rsp_if.sv =====
// Response channel: status and payload address of one result beat.
`default_nettype none

interface ffba_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [ffba_pkg::STATUS_W-1:0] status;
    logic [ffba_pkg::ADDR_W-1:0]   payload_address;

    modport source (output valid, output status, output payload_address, input ready);
    modport sink   (input valid, input status, input payload_address, output ready);
endinterface

`default_nettype wire

// ===== src/ffba_cfg_if.sv =====
// Configuration write channel: register index and write data.
`default_nettype none

interface ffba_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [ffba_pkg::CFG_IDX_W-1:0]  index;
    logic [ffba_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== src/ffba_ctrl.sv =====
// Allocator controller: request sequencing, table scan control, result hand-off.
`default_nettype none

module ffba_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    output logic              o_req_ready,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    input  ffba_pkg::t_dp_sts i_sts,
    output ffba_pkg::t_dp_cmd o_cmd
);
    import ffba_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_TAIL,
        S_FIN
    } t_state;

    t_state  r_state, n_state;
    logic    r_out_vld, n_out_vld;
    t_dp_cmd w_cmd;

    always_comb begin
        w_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    w_cmd.start = 1'b1;
                    n_state     = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.chk_vld && i_sts.hit) begin
                    w_cmd.hit_wr = 1'b1;
                    n_state      = S_FIN;
                end else if (i_sts.more) begin
                    w_cmd.issue = 1'b1;
                end else if (i_sts.is_free) begin
                    w_cmd.not_found = 1'b1;
                    n_state         = S_FIN;
                end else begin
                    n_state = S_TAIL;
                end
            end
            S_TAIL: begin
                w_cmd.tail = 1'b1;
                n_state    = S_FIN;
            end
            S_FIN: begin
                // wait here only while the previous result is still unclaimed
                if (!r_out_vld || i_out_ready) begin
                    w_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (w_cmd.load_out) begin
            n_out_vld = 1'b1;
        end else if (i_out_ready) begin
            n_out_vld = 1'b0;
        end else begin
            n_out_vld = r_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_cmd       = w_cmd;

endmodule

`default_nettype wire

// ===== src/ffba_dp.sv =====
// Allocator datapath: block table memory, scan pointer, bump pointer, result registers.
`default_nettype none

module ffba_dp #(
    parameter int MAX_BLOCKS   = ffba_pkg::MAX_BLOCKS_DEF,
    parameter int HEADER_BYTES = ffba_pkg::HEADER_BYTES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // request payload, sampled on cmd.start
    input  logic [ffba_pkg::OPCODE_W-1:0]   i_opcode,
    input  logic [ffba_pkg::SIZE_W-1:0]     i_request_bytes,
    input  logic [ffba_pkg::ADDR_W-1:0]     i_free_address,
    // configuration writes
    input  logic                            i_cfg_we,
    input  logic [ffba_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ffba_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // control
    input  ffba_pkg::t_dp_cmd               i_cmd,
    output ffba_pkg::t_dp_sts               o_sts,
    // result
    output logic [ffba_pkg::STATUS_W-1:0]   o_status,
    output logic [ffba_pkg::ADDR_W-1:0]     o_payload_address
);
    import ffba_pkg::*;

    localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam int SUM_W = ADDR_W + 1;

    localparam logic [SUM_W-1:0] HDR   = SUM_W'(HEADER_BYTES);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BLOCKS);

    // configuration
    logic [MIN_W-1:0]  r_min_alloc;
    logic [POOL_W-1:0] r_pool;

    // allocation state
    logic [CNT_W-1:0]  r_count;
    logic [ADDR_W-1:0] r_bump;

    // request
    logic [OPCODE_W-1:0] r_op;
    logic [SIZE_W-1:0]   r_size;
    logic [ADDR_W-1:0]   r_faddr;

    // scan
    logic [CNT_W-1:0] r_idx;
    logic [IDX_W-1:0] r_chk_idx;
    logic             r_chk_vld;
    t_entry           r_rd;
    t_entry           r_mem [MAX_BLOCKS];

    // result
    logic [STATUS_W-1:0] r_res_status, r_out_status;
    logic [ADDR_W-1:0]   r_res_addr, r_out_addr;

    logic [SIZE_W-1:0] w_size;
    logic [SUM_W-1:0]  w_rd_payload;
    logic [SUM_W-1:0]  w_end;
    logic [SUM_W-1:0]  w_new_payload;
    logic              w_hit;
    logic              w_fits;
    logic              w_we;
    logic [IDX_W-1:0]  w_waddr;
    t_entry            w_wdata;

    // raise small requests to the configured minimum
    assign w_size = (i_request_bytes < SIZE_W'(r_min_alloc))
                  ? SIZE_W'(r_min_alloc) : i_request_bytes;

    assign w_rd_payload  = {1'b0, r_rd.start} + HDR;
    assign w_end         = {1'b0, r_bump} + HDR + SUM_W'(r_size);
    assign w_new_payload = {1'b0, r_bump} + HDR;
    assign w_fits        = (r_count < CNT_MAX) && (w_end <= SUM_W'(r_pool));

    always_comb begin
        if (r_op == OP_FREE) begin
            w_hit = (w_rd_payload == {1'b0, r_faddr});
        end else begin
            w_hit = !r_rd.in_use && (r_rd.bytes >= r_size);
        end
    end

    // table write: mark update on a hit, or a freshly carved block
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_chk_idx;
        w_wdata = r_rd;
        if (i_cmd.hit_wr) begin
            w_we           = 1'b1;
            w_wdata.in_use = (r_op == OP_ALLOC);
        end else if (i_cmd.tail && w_fits) begin
            w_we    = 1'b1;
            w_waddr = r_count[IDX_W-1:0];
            w_wdata = '{start: r_bump, bytes: r_size, in_use: 1'b1};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (i_cmd.issue) begin
            r_rd <= r_mem[r_idx[IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_alloc <= MIN_ALLOC_RST;
            r_pool      <= POOL_RST;
            r_count     <= '0;
            r_bump      <= '0;
            r_chk_vld   <= 1'b0;
        end else begin
            if (i_cfg_we && (i_cfg_index == CFG_MIN_ALLOC)) begin
                r_min_alloc <= i_cfg_data[MIN_W-1:0];
            end
            if (i_cfg_we && (i_cfg_index == CFG_POOL)) begin
                r_pool <= i_cfg_data[POOL_W-1:0];
            end
            if (i_cmd.tail && w_fits) begin
                r_count <= r_count + CNT_W'(1);
                r_bump  <= w_end[ADDR_W-1:0];
            end
            r_chk_vld <= i_cmd.issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_op    <= i_opcode;
            r_size  <= w_size;
            r_faddr <= i_free_address;
            r_idx   <= '0;
        end else if (i_cmd.issue) begin
            r_idx <= r_idx + CNT_W'(1);
        end
        if (i_cmd.issue) begin
            r_chk_idx <= r_idx[IDX_W-1:0];
        end

        if (i_cmd.hit_wr) begin
            r_res_status <= ST_OK;
            r_res_addr   <= (r_op == OP_FREE) ? '0 : w_rd_payload[ADDR_W-1:0];
        end else if (i_cmd.not_found) begin
            r_res_status <= ST_NOTFOUND;
            r_res_addr   <= '0;
        end else if (i_cmd.tail) begin
            r_res_status <= w_fits ? ST_OK : ST_NOMEM;
            r_res_addr   <= w_fits ? w_new_payload[ADDR_W-1:0] : '0;
        end

        if (i_cmd.load_out) begin
            r_out_status <= r_res_status;
            r_out_addr   <= r_res_addr;
        end
    end

    assign o_sts.more    = (r_idx < r_count);
    assign o_sts.chk_vld = r_chk_vld;
    assign o_sts.hit     = w_hit;
    assign o_sts.is_free = (r_op == OP_FREE);

    assign o_status          = r_out_status;
    assign o_payload_address = r_out_addr;

endmodule

`default_nettype wire

// ===== src/first_fit_block_allocator.sv =====
// First-fit block allocator: top level joining controller, datapath and channels.
//
// Usage:
//   i_req carries one request a beat: opcode 0 allocates request_bytes, opcode 1
//   frees the block whose payload address is free_address. o_rsp returns one
//   beat per request: status (ok, out of memory, not found) and, for a good
//   allocate, the payload address. i_cfg writes min_alloc_bytes (index 0) or
//   pool_bytes (index 1); other indexes are dropped. i_cfg is always ready.
//   Timing: one request at a time. The table is walked one entry per cycle
//   through the memory read port. An allocate that carves a new block walks
//   the whole table, then passes the tail and finish states before its result
//   beat; a hit or an unknown free returns sooner.
//   i_req is ready again in the same cycle that the result enters the output
//   register, so a new request is not taken before the last one is finished.
//   A stalled o_rsp holds its beat; the next request is still taken and parks
//   its result until the output register frees up.
//   Reset empties the table and bump pointer and restores the register
//   defaults (8 byte minimum, 10240 byte pool); no clearing pass is needed.
`default_nettype none

module first_fit_block_allocator #(
    parameter int MAX_BLOCKS   = ffba_pkg::MAX_BLOCKS_DEF,
    parameter int HEADER_BYTES = ffba_pkg::HEADER_BYTES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ffba_req_if.sink   i_req,
    ffba_cfg_if.sink   i_cfg,
    ffba_rsp_if.source o_rsp
);
    import ffba_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    assign i_cfg.ready = 1'b1;

    ffba_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_out_ready (o_rsp.ready),
        .o_out_valid (o_rsp.valid),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    ffba_dp #(
        .MAX_BLOCKS   (MAX_BLOCKS),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_opcode          (i_req.opcode),
        .i_request_bytes   (i_req.request_bytes),
        .i_free_address    (i_req.free_address),
        .i_cfg_we          (i_cfg.valid),
        .i_cfg_index       (i_cfg.index),
        .i_cfg_data        (i_cfg.data),
        .i_cmd             (w_cmd),
        .o_sts             (w_sts),
        .o_status          (o_rsp.status),
        .o_payload_address (o_rsp.payload_address)
    );

endmodule

`default_nettype wire
